FILE: rtl/tpcg_pkg.sv
package tpcg_pkg;

    // Field widths fixed by the register map and the result word
    localparam int TEMP_W = 18;
    localparam int PCT_W  = 7;
    localparam int STEP_W = 21;
    localparam int ZONE_W = 2;

    // Usage test scales the active delta to percent
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef logic [ZONE_W-1:0] zone_t;

    localparam zone_t ZONE_PANIC = 2'd0;
    localparam zone_t ZONE_HOT   = 2'd1;
    localparam zone_t ZONE_WARM  = 2'd2;
    localparam zone_t ZONE_OK    = 2'd3;

    // Register indexes (byte address = 4 * index)
    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_CRITICAL = 3'd0;
    localparam reg_idx_t REG_HIGH     = 3'd1;
    localparam reg_idx_t REG_WARM     = 3'd2;
    localparam reg_idx_t REG_COOL     = 3'd3;
    localparam reg_idx_t REG_FLOOR    = 3'd4;
    localparam reg_idx_t REG_CEILING  = 3'd5;
    localparam reg_idx_t REG_BUSY     = 3'd6;
    localparam reg_idx_t REG_STEPS    = 3'd7;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register reset values
    localparam logic [TEMP_W-1:0] CRITICAL_RST = 18'd76000;
    localparam logic [TEMP_W-1:0] HIGH_RST     = 18'd72000;
    localparam logic [TEMP_W-1:0] WARM_RST     = 18'd68000;
    localparam logic [TEMP_W-1:0] COOL_RST     = 18'd60000;
    localparam logic [PCT_W-1:0]  FLOOR_RST    = 7'd15;
    localparam logic [PCT_W-1:0]  CEILING_RST  = 7'd90;
    localparam logic [PCT_W-1:0]  BUSY_RST     = 7'd80;
    localparam logic [STEP_W-1:0] STEPS_RST    = 21'd164500;

    // Cap after reset
    localparam logic [PCT_W-1:0]  CAP_RST      = 7'd100;

endpackage

FILE: rtl/tpcg_sample_if.sv
interface tpcg_sample_if #(
    parameter int COUNTER_WIDTH = 32
);
    import tpcg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TEMP_W-1:0]        temperature;
    logic [COUNTER_WIDTH-1:0] active_count;
    logic [COUNTER_WIDTH-1:0] idle_count;

    modport source (
        output valid, temperature, active_count, idle_count,
        input  ready
    );

    modport sink (
        input  valid, temperature, active_count, idle_count,
        output ready
    );

endinterface

FILE: rtl/tpcg_result_if.sv
interface tpcg_result_if;
    import tpcg_pkg::*;

    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] perf_cap;
    logic             cap_written;
    zone_t            zone;
    logic             counter_fault;

    modport source (
        output valid, perf_cap, cap_written, zone, counter_fault,
        input  ready
    );

    modport sink (
        input  valid, perf_cap, cap_written, zone, counter_fault,
        output ready
    );

endinterface

FILE: rtl/thermal_perf_cap_governor_unit.sv
// Channel   Kind        Word
// -------   ---------   ---------------------------------------------------
// sample    sink        temperature, active_count, idle_count (one per tick)
// result    source      perf_cap, cap_written, zone, counter_fault
// APB       slave       eight registers at byte address 4*index, pready high
//
// One word is taken per cycle if not stalled; a word sits in the input register
// after the edge that takes it and reaches the result register as it leaves (band
// logic and two narrow multiplies in between; cap, zone and counters update too).
// Reset loads register defaults, cap 100, zone ok, counters unprimed.
// A result waits in its register until taken; the input register moves on
// as soon as the result register is empty or being drained.
module thermal_perf_cap_governor_unit #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tpcg_sample_if.sink                   sample,
    tpcg_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpcg_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpcg_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpcg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tpcg_pkg::*;

    localparam int PROD_W = COUNTER_WIDTH + PCT_W;

    // Configuration registers
    logic [TEMP_W-1:0] critical_reg, high_reg, warm_reg, cool_reg;
    logic [PCT_W-1:0]  floor_reg, ceiling_reg, busy_reg;
    logic [STEP_W-1:0] steps_reg;

    // Input register
    logic                     s1_valid_reg;
    logic [TEMP_W-1:0]        s1_temp_reg;
    logic [COUNTER_WIDTH-1:0] s1_active_reg;
    logic [COUNTER_WIDTH-1:0] s1_idle_reg;

    // Governor state
    logic [PCT_W-1:0]         cap_reg, cap_next;
    zone_t                    zone_reg, zone_next;
    logic [COUNTER_WIDTH-1:0] prev_active_reg, prev_active_next;
    logic [COUNTER_WIDTH-1:0] prev_idle_reg, prev_idle_next;
    logic                     written, fault;

    // Result register
    logic             out_valid_reg;
    logic [PCT_W-1:0] out_cap_reg;
    logic             out_written_reg;
    zone_t            out_zone_reg;
    logic             out_fault_reg;

    logic cfg_write;
    logic s1_move, s1_fire, in_fire;

    // Handshake
    assign s1_move      = !out_valid_reg || result.ready;
    assign s1_fire      = s1_valid_reg && s1_move;
    assign sample.ready = !s1_valid_reg || s1_move;
    assign in_fire      = sample.valid && sample.ready;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_reg <= CRITICAL_RST;
            high_reg     <= HIGH_RST;
            warm_reg     <= WARM_RST;
            cool_reg     <= COOL_RST;
            floor_reg    <= FLOOR_RST;
            ceiling_reg  <= CEILING_RST;
            busy_reg     <= BUSY_RST;
            steps_reg    <= STEPS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_CRITICAL: critical_reg <= pwdata[TEMP_W-1:0];
                REG_HIGH:     high_reg     <= pwdata[TEMP_W-1:0];
                REG_WARM:     warm_reg     <= pwdata[TEMP_W-1:0];
                REG_COOL:     cool_reg     <= pwdata[TEMP_W-1:0];
                REG_FLOOR:    floor_reg    <= pwdata[PCT_W-1:0];
                REG_CEILING:  ceiling_reg  <= pwdata[PCT_W-1:0];
                REG_BUSY:     busy_reg     <= pwdata[PCT_W-1:0];
                REG_STEPS:    steps_reg    <= pwdata[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[PADDR_W-1:2])
            REG_CRITICAL: prdata = PDATA_W'(critical_reg);
            REG_HIGH:     prdata = PDATA_W'(high_reg);
            REG_WARM:     prdata = PDATA_W'(warm_reg);
            REG_COOL:     prdata = PDATA_W'(cool_reg);
            REG_FLOOR:    prdata = PDATA_W'(floor_reg);
            REG_CEILING:  prdata = PDATA_W'(ceiling_reg);
            REG_BUSY:     prdata = PDATA_W'(busy_reg);
            REG_STEPS:    prdata = PDATA_W'(steps_reg);
            default:      prdata = '0;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_temp_reg   <= sample.temperature;
            s1_active_reg <= sample.active_count;
            s1_idle_reg   <= sample.idle_count;
        end
    end

    // Step fields
    logic [PCT_W-1:0] step_large, step_small, step_inc;
    assign step_large = steps_reg[PCT_W-1:0];
    assign step_small = steps_reg[2*PCT_W-1:PCT_W];
    assign step_inc   = steps_reg[3*PCT_W-1:2*PCT_W];

    // Decrease with floor, signed so a floor above the cap lifts it
    logic signed [PCT_W:0] dec_large_s, dec_small_s, floor_s;
    logic [PCT_W-1:0]      dec_large_cap, dec_small_cap;

    assign floor_s       = $signed({1'b0, floor_reg});
    assign dec_large_s   = $signed({1'b0, cap_reg}) - $signed({1'b0, step_large});
    assign dec_small_s   = $signed({1'b0, cap_reg}) - $signed({1'b0, step_small});
    assign dec_large_cap = (dec_large_s < floor_s) ? floor_reg : dec_large_s[PCT_W-1:0];
    assign dec_small_cap = (dec_small_s < floor_s) ? floor_reg : dec_small_s[PCT_W-1:0];

    // Increase with ceiling
    logic [PCT_W:0]   up_sum;
    logic [PCT_W-1:0] inc_cap;

    assign up_sum  = {1'b0, cap_reg} + {1'b0, step_inc};
    assign inc_cap = ({1'b0, ceiling_reg} < up_sum) ? ceiling_reg : up_sum[PCT_W-1:0];

    // Usage test: active delta * 100 > threshold * idle delta, exact
    logic [COUNTER_WIDTH-1:0] act_delta, idle_delta;
    logic [PROD_W-1:0]        act_prod, idle_prod;
    logic                     busy_hit;

    assign act_delta  = s1_active_reg - prev_active_reg;
    assign idle_delta = s1_idle_reg - prev_idle_reg;
    assign act_prod   = {{PCT_W{1'b0}}, act_delta} * {{COUNTER_WIDTH{1'b0}}, PCT_SCALE};
    assign idle_prod  = {{PCT_W{1'b0}}, idle_delta} * {{COUNTER_WIDTH{1'b0}}, busy_reg};
    assign busy_hit   = act_prod > idle_prod;

    // Band logic
    always_comb
    begin
        cap_next         = cap_reg;
        zone_next        = zone_reg;
        prev_active_next = prev_active_reg;
        prev_idle_next   = prev_idle_reg;
        written          = 1'b0;
        fault            = 1'b0;

        if (s1_temp_reg > critical_reg)
        begin
            cap_next  = floor_reg;
            zone_next = ZONE_PANIC;
            written   = 1'b1;
        end
        else if (s1_temp_reg > high_reg)
        begin
            if (zone_reg != ZONE_PANIC)
            begin
                cap_next  = dec_large_cap;
                zone_next = ZONE_HOT;
                written   = 1'b1;
            end
        end
        else if (s1_temp_reg > warm_reg)
        begin
            if (zone_reg != ZONE_PANIC)
            begin
                cap_next  = dec_small_cap;
                zone_next = ZONE_WARM;
                written   = 1'b1;
            end
        end
        else if (s1_temp_reg > cool_reg)
        begin
            if (zone_reg == ZONE_PANIC)
            begin
                zone_next = ZONE_OK;
            end
        end
        else if (prev_active_reg == '0)
        begin
            // unprimed: a zero sample is a fault, otherwise just prime
            if (s1_active_reg == '0)
            begin
                fault = 1'b1;
            end
            else
            begin
                prev_active_next = s1_active_reg;
                prev_idle_next   = s1_idle_reg;
                if (zone_reg == ZONE_PANIC)
                begin
                    zone_next = ZONE_OK;
                end
            end
        end
        else
        begin
            prev_active_next = s1_active_reg;
            prev_idle_next   = s1_idle_reg;
            if (zone_reg == ZONE_PANIC)
            begin
                zone_next = ZONE_OK;
            end
            if (busy_hit)
            begin
                cap_next = inc_cap;
                written  = 1'b1;
            end
        end
    end

    // State update when a word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= CAP_RST;
            zone_reg        <= ZONE_OK;
            prev_active_reg <= '0;
            prev_idle_reg   <= '0;
        end
        else if (s1_fire)
        begin
            cap_reg         <= cap_next;
            zone_reg        <= zone_next;
            prev_active_reg <= prev_active_next;
            prev_idle_reg   <= prev_idle_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_cap_reg     <= cap_next;
            out_written_reg <= written;
            out_zone_reg    <= zone_next;
            out_fault_reg   <= fault;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.perf_cap      = out_cap_reg;
    assign result.cap_written   = out_written_reg;
    assign result.zone          = out_zone_reg;
    assign result.counter_fault = out_fault_reg;

`ifndef NO_ASSERTIONS
    // A counter fault never comes with a cap write
    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fault_reg |-> !out_written_reg)
        else $error("counter fault reported together with a cap write");

    // Governor state only moves when a word is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(cap_reg) && $stable(zone_reg) && $stable(prev_active_reg))
        else $error("governor state changed without a word");

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample.ready)
        else $error("input stalled while result register empty");

    // A hot or warm decrease never lands below the floor
    a_floor_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && written && s1_temp_reg > warm_reg && s1_temp_reg <= critical_reg
        |-> cap_next >= floor_reg)
        else $error("decreased cap below floor");
`endif

endmodule

FILE: test/thermal_perf_cap_governor_unit_test.sv
`timescale 1ns / 1ps

module thermal_perf_cap_governor_unit_test;
    import tpcg_pkg::*;

    localparam int          CNT_W    = 32;
    localparam int unsigned TEMP_MAX = (1 << TEMP_W) - 1;
    localparam int unsigned STEP_MAX = (1 << STEP_W) - 1;

    // One result word as the block reports it
    typedef struct packed {
        logic [PCT_W-1:0] perf_cap;
        logic             cap_written;
        zone_t            zone;
        logic             counter_fault;
    } cap_word_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tpcg_sample_if #(.COUNTER_WIDTH(CNT_W)) sample_bus ();
    tpcg_result_if                          result_bus ();

    thermal_perf_cap_governor_unit #(
        .COUNTER_WIDTH (CNT_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Governor mirror: configuration
    logic [TEMP_W-1:0] gov_crit;
    logic [TEMP_W-1:0] gov_high;
    logic [TEMP_W-1:0] gov_warm;
    logic [TEMP_W-1:0] gov_cool;
    logic [PCT_W-1:0]  gov_floor;
    logic [PCT_W-1:0]  gov_ceil;
    logic [PCT_W-1:0]  gov_busy;
    logic [STEP_W-1:0] gov_steps;

    // Governor mirror: state
    logic [PCT_W-1:0]  gov_cap;
    zone_t             gov_zone;
    logic [CNT_W-1:0]  gov_prev_act;
    logic [CNT_W-1:0]  gov_prev_idl;

    // Words predicted but not yet seen on the result channel
    cap_word_t predicted_words[$];

    // Running counters for well-formed sample streams
    logic [CNT_W-1:0] act_run;
    logic [CNT_W-1:0] idl_run;

    bit sender_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    int stall_left     = 0;

    int mismatches      = 0;
    int ticks_sent      = 0;
    int words_checked   = 0;
    int cap_writes_seen = 0;
    int panic_seen      = 0;
    int faults_seen     = 0;
    int cfg_writes      = 0;
    int settings_used   = 0;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("thermal_perf_cap_governor_unit_test: FAIL");
        $display("run limit reached with %0d words outstanding", predicted_words.size());
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Idle stretch length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Decrease floored at gov_floor, done signed so a high floor can raise the cap
    function automatic logic [PCT_W-1:0] lower_cap(input logic [PCT_W-1:0] step);
        int level;
        level = int'(gov_cap) - int'(step);
        if (level < int'(gov_floor))
            level = int'(gov_floor);
        return level[PCT_W-1:0];
    endfunction

    // Advance the mirror by one tick and form the word it should produce
    task automatic advance_governor(input logic [TEMP_W-1:0] temp,
                                    input logic [CNT_W-1:0] act,
                                    input logic [CNT_W-1:0] idl,
                                    output cap_word_t word);
        logic [PCT_W-1:0] step_big;
        logic [PCT_W-1:0] step_fine;
        logic [PCT_W-1:0] step_up;
        logic [CNT_W-1:0] d_act;
        logic [CNT_W-1:0] d_idl;
        logic [63:0]      busy_lhs;
        logic [63:0]      busy_rhs;
        int               level;
        logic             written;
        logic             fault;

        step_big  = gov_steps[6:0];
        step_fine = gov_steps[13:7];
        step_up   = gov_steps[20:14];
        written   = 1'b0;
        fault     = 1'b0;

        if (temp > gov_crit)
        begin
            gov_cap  = gov_floor;
            gov_zone = ZONE_PANIC;
            written  = 1'b1;
        end
        else if (temp > gov_high)
        begin
            if (gov_zone != ZONE_PANIC)
            begin
                gov_cap  = lower_cap(step_big);
                gov_zone = ZONE_HOT;
                written  = 1'b1;
            end
        end
        else if (temp > gov_warm)
        begin
            if (gov_zone != ZONE_PANIC)
            begin
                gov_cap  = lower_cap(step_fine);
                gov_zone = ZONE_WARM;
                written  = 1'b1;
            end
        end
        else if (temp > gov_cool)
        begin
            if (gov_zone == ZONE_PANIC)
                gov_zone = ZONE_OK;
        end
        else if (gov_prev_act == '0)
        begin
            // not primed: a zero sample is a fault, anything else primes
            if (act == '0)
                fault = 1'b1;
            else
            begin
                gov_prev_act = act;
                gov_prev_idl = idl;
                if (gov_zone == ZONE_PANIC)
                    gov_zone = ZONE_OK;
            end
        end
        else
        begin
            d_act        = act - gov_prev_act;
            d_idl        = idl - gov_prev_idl;
            gov_prev_act = act;
            gov_prev_idl = idl;
            if (gov_zone == ZONE_PANIC)
                gov_zone = ZONE_OK;
            busy_lhs = 64'(d_act) * 64'(PCT_SCALE);
            busy_rhs = 64'(d_idl) * 64'(gov_busy);
            if (busy_lhs > busy_rhs)
            begin
                level = int'(gov_cap) + int'(step_up);
                if (int'(gov_ceil) < level)
                    gov_cap = gov_ceil;
                else
                    gov_cap = level[PCT_W-1:0];
                written = 1'b1;
            end
        end

        word.perf_cap      = gov_cap;
        word.cap_written   = written;
        word.zone          = gov_zone;
        word.counter_fault = fault;
    endtask

    // Offer one word on the sample channel, record its prediction on acceptance
    task automatic send_tick(input logic [TEMP_W-1:0] temp,
                             input logic [CNT_W-1:0] act,
                             input logic [CNT_W-1:0] idl);
        cap_word_t word;
        int        gap;

        @(negedge clk);
        sample_bus.valid        = 1'b1;
        sample_bus.temperature  = temp;
        sample_bus.active_count = act;
        sample_bus.idle_count   = idl;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        advance_governor(temp, act, idl, word);
        predicted_words.push_back(word);
        ticks_sent++;

        gap = 0;
        if (sender_gaps_on && $urandom_range(0, 99) >= 55)
            gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and let every predicted word arrive, plus pipeline slack
    task automatic wait_drained();
        @(negedge clk);
        sample_bus.valid = 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Temperatures clustered on the thresholds, below cool, or anywhere
    function automatic logic [TEMP_W-1:0] pick_temp();
        int                roll;
        int                level;
        logic [TEMP_W-1:0] mark;

        roll = $urandom_range(0, 99);
        if (roll < 15)
            return TEMP_W'($urandom_range(0, TEMP_MAX));
        if (roll < 45)
            return TEMP_W'($urandom_range(0, gov_cool));
        case ($urandom_range(0, 3))
            0:       mark = gov_crit;
            1:       mark = gov_high;
            2:       mark = gov_warm;
            default: mark = gov_cool;
        endcase
        level = int'(mark) + int'($urandom_range(0, 40)) - 20;
        if (level < 0)
            level = 0;
        if (level > int'(TEMP_MAX))
            level = int'(TEMP_MAX);
        return TEMP_W'(level);
    endfunction

    // Mostly advancing counters with random deltas; some noise, resets and wraps
    task automatic send_random_ticks(input int count);
        int roll;

        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                act_run += CNT_W'($urandom_range(0, 2000));
                if ($urandom_range(0, 99) >= 20)
                    idl_run += CNT_W'($urandom_range(0, 2000));
            end
            else if (roll < 85)
            begin
                act_run = CNT_W'($urandom);
                idl_run = CNT_W'($urandom);
            end
            else if (roll < 91)
            begin
                act_run = '0;
                idl_run = CNT_W'($urandom);
            end
            else
            begin
                act_run = CNT_W'(32'hFFFF_FF00 + $urandom_range(0, 255));
                idl_run = CNT_W'(32'hFFFF_FF00 + $urandom_range(0, 255));
            end
            send_tick(pick_temp(), act_run, idl_run);
        end
    endtask

    // One APB transfer: setup then access, data taken when pready is high
    task automatic apb_access(input bit write, input reg_idx_t idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input reg_idx_t idx, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;

        apb_access(1'b0, idx, '0, got);
        if (got !== want)
            note_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, got, want));
    endtask

    // Write a register, mirror it, and read it back
    task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        logic [PDATA_W-1:0] kept;

        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_CRITICAL: begin gov_crit  = value[TEMP_W-1:0]; kept = PDATA_W'(gov_crit);  end
            REG_HIGH:     begin gov_high  = value[TEMP_W-1:0]; kept = PDATA_W'(gov_high);  end
            REG_WARM:     begin gov_warm  = value[TEMP_W-1:0]; kept = PDATA_W'(gov_warm);  end
            REG_COOL:     begin gov_cool  = value[TEMP_W-1:0]; kept = PDATA_W'(gov_cool);  end
            REG_FLOOR:    begin gov_floor = value[PCT_W-1:0];  kept = PDATA_W'(gov_floor); end
            REG_CEILING:  begin gov_ceil  = value[PCT_W-1:0];  kept = PDATA_W'(gov_ceil);  end
            REG_BUSY:     begin gov_busy  = value[PCT_W-1:0];  kept = PDATA_W'(gov_busy);  end
            default:      begin gov_steps = value[STEP_W-1:0]; kept = PDATA_W'(gov_steps); end
        endcase
        check_register(idx, kept);
        cfg_writes++;
    endtask

    // Full register set, written only once the block has gone quiet
    task automatic load_config(input int unsigned crit, input int unsigned high,
                               input int unsigned warm, input int unsigned cool,
                               input int unsigned floor_pct, input int unsigned ceil_pct,
                               input int unsigned busy_pct, input int unsigned steps);
        wait_drained();
        cfg_write(REG_CRITICAL, crit);
        cfg_write(REG_HIGH, high);
        cfg_write(REG_WARM, warm);
        cfg_write(REG_COOL, cool);
        cfg_write(REG_FLOOR, floor_pct);
        cfg_write(REG_CEILING, ceil_pct);
        cfg_write(REG_BUSY, busy_pct);
        cfg_write(REG_STEPS, steps);
        settings_used++;
    endtask

    // Result channel: random backpressure unless switched to always-ready
    always @(negedge clk)
    begin
        if (!sink_stalls_on)
            result_bus.ready = 1'b1;
        else if (stall_left > 0)
        begin
            result_bus.ready = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < 70)
            result_bus.ready = 1'b1;
        else
        begin
            result_bus.ready = 1'b0;
            stall_left       = pick_gap() - 1;
        end
    end

    // Compare each delivered word with the oldest prediction
    always @(posedge clk)
    begin
        cap_word_t got;
        cap_word_t want;

        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.perf_cap      = result_bus.perf_cap;
            got.cap_written   = result_bus.cap_written;
            got.zone          = result_bus.zone;
            got.counter_fault = result_bus.counter_fault;
            if (predicted_words.size() == 0)
                note_mismatch($sformatf("word with nothing pending: cap=%0d wr=%0b zone=%0d flt=%0b",
                                        got.perf_cap, got.cap_written, got.zone,
                                        got.counter_fault));
            else
            begin
                want = predicted_words.pop_front();
                if (got.perf_cap !== want.perf_cap || got.cap_written !== want.cap_written ||
                    got.zone !== want.zone || got.counter_fault !== want.counter_fault)
                    note_mismatch($sformatf({"word %0d: expected cap=%0d wr=%0b zone=%0d flt=%0b,",
                                             " got cap=%0d wr=%0b zone=%0d flt=%0b"},
                                            words_checked, want.perf_cap, want.cap_written,
                                            want.zone, want.counter_fault, got.perf_cap,
                                            got.cap_written, got.zone, got.counter_fault));
                words_checked++;
                if (want.cap_written)
                    cap_writes_seen++;
                if (want.zone == ZONE_PANIC)
                    panic_seen++;
                if (want.counter_fault)
                    faults_seen++;
            end
        end
    end

    // Registers come out of reset at their documented values
    task automatic test_register_defaults();
        check_register(REG_CRITICAL, PDATA_W'(CRITICAL_RST));
        check_register(REG_HIGH, PDATA_W'(HIGH_RST));
        check_register(REG_WARM, PDATA_W'(WARM_RST));
        check_register(REG_COOL, PDATA_W'(COOL_RST));
        check_register(REG_FLOOR, PDATA_W'(FLOOR_RST));
        check_register(REG_CEILING, PDATA_W'(CEILING_RST));
        check_register(REG_BUSY, PDATA_W'(BUSY_RST));
        check_register(REG_STEPS, PDATA_W'(STEPS_RST));
    endtask

    // Hand-picked ticks through every band and counter corner
    task automatic test_directed_bands();
        // zero sample while unprimed, then prime exactly at the cool threshold
        send_tick(18'd0, 32'd0, 32'd0);
        send_tick(18'd60000, 32'd100, 32'd50);
        // zero idle delta passes; increase clips a cap above the ceiling
        send_tick(18'd60000, 32'd1100, 32'd50);
        // threshold equality stays in the lower band
        send_tick(18'd68000, 32'd0, 32'd0);
        send_tick(18'd68001, 32'd0, 32'd0);
        send_tick(18'd72001, 32'd0, 32'd0);
        // panic, then hot and warm leave the cap alone until normal clears it
        send_tick(18'd76001, 32'd0, 32'd0);
        send_tick(TEMP_W'(TEMP_MAX), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(18'd72001, 32'd0, 32'd0);
        send_tick(18'd68001, 32'd0, 32'd0);
        send_tick(18'd60001, 32'd0, 32'd0);
        send_tick(18'd76001, 32'd0, 32'd0);
        // cool band clears panic and raises
        send_tick(18'd0, 32'd2100, 32'd60);
        // full-scale deltas, then wrapped deltas
        send_tick(18'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(18'd0, 32'h0000_0010, 32'h0000_0005);
        send_tick(18'd0, 32'h0000_0010, 32'h0000_0100);
        // zero sample while primed unprimes; next zero sample faults
        send_tick(18'd0, 32'd0, 32'd0);
        send_tick(18'd0, 32'd0, 32'd7);
        send_tick(18'd0, 32'd5, 32'd0);
        // usage exactly at threshold does not raise, just above does
        send_tick(18'd0, 32'd9, 32'd5);
        send_tick(18'd0, 32'd14, 32'd9);
        // floor above the cap: a decrease raises the cap to the floor
        wait_drained();
        cfg_write(REG_FLOOR, 32'd100);
        send_tick(18'd72001, 32'd0, 32'd0);
        send_tick(18'd68001, 32'd0, 32'd0);
        wait_drained();
        cfg_write(REG_FLOOR, 32'(FLOOR_RST));
    endtask

    // Register extremes, unordered thresholds and random settings
    task automatic test_config_sweep();
        int unsigned cool;

        load_config(0, 0, 0, 0, 0, 0, 0, 0);
        send_random_ticks(45);
        load_config(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, 100, 100, 100, STEP_MAX);
        send_random_ticks(45);
        load_config(1000, 50000, 200000, 150000, 50, 20, 30,
                    $urandom_range(0, STEP_MAX));
        send_random_ticks(45);
        repeat (4)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                cool = $urandom_range(0, 200000);
                load_config(cool + 3 * $urandom_range(0, 20000) / 3 + 40000,
                            cool + $urandom_range(0, 20000) + 20000,
                            cool + $urandom_range(0, 20000),
                            cool,
                            $urandom_range(0, 100), $urandom_range(0, 100),
                            $urandom_range(0, 100), $urandom_range(0, STEP_MAX));
            end
            else
                load_config($urandom_range(0, TEMP_MAX), $urandom_range(0, TEMP_MAX),
                            $urandom_range(0, TEMP_MAX), $urandom_range(0, TEMP_MAX),
                            $urandom_range(0, 100), $urandom_range(0, 100),
                            $urandom_range(0, 100), $urandom_range(0, STEP_MAX));
            send_random_ticks(45);
        end
        load_config(CRITICAL_RST, HIGH_RST, WARM_RST, COOL_RST,
                    FLOOR_RST, CEILING_RST, BUSY_RST, STEPS_RST);
        send_random_ticks(45);
    endtask

    // Bulk random traffic at the default thresholds
    task automatic test_random_traffic();
        send_random_ticks(380);
    endtask

    // Short bursts, each followed by a full drain before the next
    task automatic test_drain_between_bursts();
        repeat (10)
        begin
            send_random_ticks($urandom_range(1, 6));
            wait_drained();
        end
    endtask

    // Full-rate stretch: no sender gaps, no result stalls
    task automatic test_back_to_back();
        wait_drained();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        send_random_ticks(60);
        wait_drained();
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        sample_bus.valid        = 1'b0;
        sample_bus.temperature  = '0;
        sample_bus.active_count = '0;
        sample_bus.idle_count   = '0;
        result_bus.ready        = 1'b0;

        // mirror starts from the reset state
        gov_crit     = CRITICAL_RST;
        gov_high     = HIGH_RST;
        gov_warm     = WARM_RST;
        gov_cool     = COOL_RST;
        gov_floor    = FLOOR_RST;
        gov_ceil     = CEILING_RST;
        gov_busy     = BUSY_RST;
        gov_steps    = STEPS_RST;
        gov_cap      = CAP_RST;
        gov_zone     = ZONE_OK;
        gov_prev_act = '0;
        gov_prev_idl = '0;
        act_run      = '0;
        idl_run      = '0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_register_defaults();
        test_directed_bands();
        test_config_sweep();
        test_random_traffic();
        test_drain_between_bursts();
        test_back_to_back();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d ticks under %0d register settings, %0d register writes read back.",
                 ticks_sent, settings_used, cfg_writes);
        $display("Checked %0d words: %0d cap writes, %0d in panic, %0d counter faults.",
                 words_checked, cap_writes_seen, panic_seen, faults_seen);
        if (mismatches == 0 && predicted_words.size() == 0)
            $display("thermal_perf_cap_governor_unit_test: PASS");
        else
            $display("thermal_perf_cap_governor_unit_test: FAIL");
        $finish;
    end

endmodule
